@@ rtl/dnrs_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and helpers for the directional nearest rectangle select unit
// no dependencies
package dnrs_pkg;

  localparam int COORD_BITS = 10;
  localparam int SIZE_BITS  = COORD_BITS + 1;
  localparam int GAP_BITS   = COORD_BITS + 1;
  localparam int DEV_BITS   = COORD_BITS + 2;
  localparam int ID_BITS    = 6;
  localparam int ARITH_BITS = COORD_BITS + 4;   // signed width for sums and differences
  localparam int CFG_BITS   = SIZE_BITS;        // widest register
  localparam int CFG_IDX_BITS = 3;
  localparam int IN_BITS    = ID_BITS + 2 * COORD_BITS + 2 * SIZE_BITS;
  localparam int IN_BYTES_BITS = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 1 + ID_BITS + GAP_BITS + DEV_BITS;
  localparam int OUT_BYTES_BITS = ((OUT_BITS + 7) / 8) * 8;

  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_UP    = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FOCUS_X     = 3'd0,
    REG_FOCUS_Y     = 3'd1,
    REG_FOCUS_W     = 3'd2,
    REG_FOCUS_H     = 3'd3,
    REG_DIRECTION   = 3'd4,
    REG_FOCUSED_ID  = 3'd5,
    REG_FOCUS_VALID = 3'd6
  } cfg_reg_t;

  // one classified candidate as it sits in the queue
  typedef struct packed {
    logic                ok;
    logic                last;
    logic [ID_BITS-1:0]  id;
    logic [GAP_BITS-1:0] gap;
    logic [DEV_BITS-1:0] dev;
  } dnrs_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dnrs_qstat_t;

  function automatic logic signed [ARITH_BITS-1:0] ext_coord(input logic [COORD_BITS-1:0] v);
    return $signed({{(ARITH_BITS - COORD_BITS){1'b0}}, v});
  endfunction

  function automatic logic signed [ARITH_BITS-1:0] ext_size(input logic [SIZE_BITS-1:0] v);
    return $signed({{(ARITH_BITS - SIZE_BITS){v[SIZE_BITS-1]}}, v});
  endfunction

endpackage

@@ rtl/dnrs_front.sv @@
`timescale 1ns / 1ps
// front end: configuration registers, candidate intake and classification
// depends on dnrs_pkg
module dnrs_front import dnrs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_BYTES_BITS-1:0]  s_tdata,
  input  logic                      s_tlast,
  input  dnrs_qstat_t               qstat,
  output logic                      push,
  output dnrs_rec_t                 push_rec
);

  logic [COORD_BITS-1:0] focus_x;
  logic [COORD_BITS-1:0] focus_y;
  logic [SIZE_BITS-1:0]  focus_w;
  logic [SIZE_BITS-1:0]  focus_h;
  dir_t                  direction;
  logic [ID_BITS-1:0]    focused_id;
  logic                  focus_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      focus_x     <= '0;
      focus_y     <= '0;
      focus_w     <= '0;
      focus_h     <= '0;
      direction   <= DIR_LEFT;
      focused_id  <= '0;
      focus_valid <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FOCUS_X:     focus_x     <= cfg_data[COORD_BITS-1:0];
        REG_FOCUS_Y:     focus_y     <= cfg_data[COORD_BITS-1:0];
        REG_FOCUS_W:     focus_w     <= cfg_data[SIZE_BITS-1:0];
        REG_FOCUS_H:     focus_h     <= cfg_data[SIZE_BITS-1:0];
        REG_DIRECTION:   direction   <= dir_t'(cfg_data[1:0]);
        REG_FOCUSED_ID:  focused_id  <= cfg_data[ID_BITS-1:0];
        REG_FOCUS_VALID: focus_valid <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [ID_BITS-1:0]    cand_id;
  logic [COORD_BITS-1:0] cand_x;
  logic [COORD_BITS-1:0] cand_y;
  logic [SIZE_BITS-1:0]  cand_w;
  logic [SIZE_BITS-1:0]  cand_h;

  assign cand_id = s_tdata[ID_BITS-1:0];
  assign cand_x  = s_tdata[ID_BITS +: COORD_BITS];
  assign cand_y  = s_tdata[ID_BITS + COORD_BITS +: COORD_BITS];
  assign cand_w  = s_tdata[ID_BITS + 2*COORD_BITS +: SIZE_BITS];
  assign cand_h  = s_tdata[ID_BITS + 2*COORD_BITS + SIZE_BITS +: SIZE_BITS];

  logic horiz, fwd;
  logic signed [ARITH_BITS-1:0] a_c, a_cs, a_f, a_fs;   // along travel
  logic signed [ARITH_BITS-1:0] x_c, x_cs, x_f, x_fs;   // across travel
  logic signed [ARITH_BITS-1:0] gap, dev, dev_abs;
  logic overlap, size_ok;

  always_comb begin
    horiz = (direction == DIR_LEFT) || (direction == DIR_RIGHT);
    fwd   = (direction == DIR_DOWN) || (direction == DIR_RIGHT);
    a_c   = horiz ? ext_coord(cand_x)  : ext_coord(cand_y);
    a_cs  = horiz ? ext_size(cand_w)   : ext_size(cand_h);
    a_f   = horiz ? ext_coord(focus_x) : ext_coord(focus_y);
    a_fs  = horiz ? ext_size(focus_w)  : ext_size(focus_h);
    x_c   = horiz ? ext_coord(cand_y)  : ext_coord(cand_x);
    x_cs  = horiz ? ext_size(cand_h)   : ext_size(cand_w);
    x_f   = horiz ? ext_coord(focus_y) : ext_coord(focus_x);
    x_fs  = horiz ? ext_size(focus_h)  : ext_size(focus_w);

    gap     = fwd ? (a_c - (a_f + a_fs)) : (a_f - (a_c + a_cs));
    overlap = (x_c < (x_f + x_fs)) && (x_f < (x_c + x_cs));
    dev     = (x_c + x_c + x_cs) - (x_f + x_f + x_fs);
    dev_abs = dev[ARITH_BITS-1] ? -dev : dev;
    size_ok = !cand_w[SIZE_BITS-1] && (cand_w != '0) &&
              !cand_h[SIZE_BITS-1] && (cand_h != '0);

    push_rec.ok   = focus_valid && (cand_id != focused_id) && size_ok && overlap &&
                    !gap[ARITH_BITS-1];
    push_rec.last = s_tlast;
    push_rec.id   = cand_id;
    push_rec.gap  = gap[GAP_BITS-1:0];
    push_rec.dev  = dev_abs[DEV_BITS-1:0];
  end

  assign s_tready = !qstat.full;
  assign push     = s_tvalid && s_tready;

endmodule

@@ rtl/dnrs_queue.sv @@
`timescale 1ns / 1ps
// short word queue between the classifying front and the selecting back end
// depends on dnrs_pkg
module dnrs_queue import dnrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  dnrs_rec_t   push_rec,
  input  logic        pop,
  output dnrs_rec_t   head,
  output dnrs_qstat_t qstat
);

  dnrs_rec_t            slots [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count, count_next;

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + QCNT_BITS'(1);
    if (pop && !push) count_next = count - QCNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_BITS'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_BITS'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_rec;
  end

  assign head        = slots[rd_ptr];
  assign qstat.full  = (count == QCNT_BITS'(QDEPTH));
  assign qstat.empty = (count == '0);

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && qstat.full)) else $error("queue written while full");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule

@@ rtl/dnrs_back.sv @@
`timescale 1ns / 1ps
// back end: running best selection and the result output register
// depends on dnrs_pkg
module dnrs_back import dnrs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  dnrs_qstat_t               qstat,
  input  dnrs_rec_t                 head,
  output logic                      pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_BYTES_BITS-1:0] m_tdata
);

  logic                have_best;
  logic [GAP_BITS-1:0] kept_gap;
  logic [DEV_BITS-1:0] kept_dev;
  logic [ID_BITS-1:0]  kept_id;

  logic                have_best_next;
  logic [GAP_BITS-1:0] kept_gap_next;
  logic [DEV_BITS-1:0] kept_dev_next;
  logic [ID_BITS-1:0]  kept_id_next;
  logic                better, out_free, pop_last;

  // a last word needs the output register free, other words pop freely
  assign out_free = !m_tvalid || m_tready;
  assign pop      = !qstat.empty && (!head.last || out_free);
  assign pop_last = pop && head.last;

  always_comb begin
    better = head.ok && (!have_best || (head.gap < kept_gap) ||
             ((head.gap == kept_gap) && (head.dev < kept_dev)));
    have_best_next = have_best || better;
    kept_gap_next  = better ? head.gap : kept_gap;
    kept_dev_next  = better ? head.dev : kept_dev;
    kept_id_next   = better ? head.id  : kept_id;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
      kept_gap  <= '0;
      kept_dev  <= '0;
      kept_id   <= '0;
    end else if (pop_last) begin
      have_best <= 1'b0;
      kept_gap  <= '0;
      kept_dev  <= '0;
      kept_id   <= '0;
    end else if (pop) begin
      have_best <= have_best_next;
      kept_gap  <= kept_gap_next;
      kept_dev  <= kept_dev_next;
      kept_id   <= kept_id_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // kept fields are zero whenever nothing has been kept, so no masking here
  always_ff @(posedge clk) begin
    if (pop_last) begin
      m_tdata <= OUT_BYTES_BITS'({kept_dev_next, kept_gap_next, kept_id_next, have_best_next});
    end
  end

`ifndef SYNTH
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    pop_last |=> !have_best) else $error("search state not cleared after last word");
  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    !have_best |-> (kept_id == '0) && (kept_gap == '0) && (kept_dev == '0))
    else $error("kept fields nonzero without a kept candidate");
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    pop_last |-> out_free) else $error("result register overwritten while held");
`endif

endmodule

@@ rtl/directional_nearest_rect_select_unit.sv @@
`timescale 1ns / 1ps
// top level of the directional nearest rectangle select unit
// depends on dnrs_pkg, dnrs_front, dnrs_queue, dnrs_back
//
// usage
//   config: write the focused rectangle, its id, the valid flag and the direction
//   through cfg_we / cfg_index / cfg_data while no search is in flight
//   s_* channel: one candidate rectangle per word, s_tlast on the final one
//   m_* channel: one result word per search, sent after the word marked last
// dataflow
//   one candidate word is taken every cycle while the queue is not full; the front
//   classifies it in the cycle it is accepted and writes it into a four-entry queue;
//   the back end updates the running best from the queue head, one word per cycle
//   unless a last word waits on a held result; popping the last word sets m_tvalid
// reset
//   rst (synchronous) clears the config registers, the queue and the search state
// stalls
//   a held result blocks only the next last word at the queue head; other words keep
//   flowing until the queue fills, then s_tready drops
module directional_nearest_rect_select_unit import dnrs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_we,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  // candidate stream
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_BYTES_BITS-1:0]  s_tdata,   // cand_id, cand_x, cand_y, cand_w, cand_h
  input  logic                      s_tlast,   // cand_last
  // result stream
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_BYTES_BITS-1:0] m_tdata    // found, best_id, best_gap, best_deviation
);

  dnrs_qstat_t qstat;
  dnrs_rec_t   push_rec, head;
  logic        push, pop;

  // classification of each candidate against the focus
  dnrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .qstat     (qstat),
    .push      (push),
    .push_rec  (push_rec)
  );

  // decouples intake from result backpressure
  dnrs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  // lexicographic min over (gap, deviation), first wins on ties
  dnrs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .qstat    (qstat),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
